// File: src/c8ie_pkg.sv
// ----------------------------------------------------------------------------
// c8ie_pkg
// Shared types, constants and helpers of the CHIP-8 execute block.
// ----------------------------------------------------------------------------
`default_nettype none

package c8ie_pkg;

  localparam int MEM_BYTES   = 4096;
  localparam int MEM_AW      = $clog2(MEM_BYTES);
  localparam int SCREEN_W    = 64;
  localparam int SCREEN_H    = 32;
  localparam int ROW_AW      = $clog2(SCREEN_H);
  localparam int COL_AW      = $clog2(SCREEN_W);
  localparam int STACK_DEPTH = 16;
  localparam int SP_AW       = $clog2(STACK_DEPTH);
  localparam int Q_DEPTH     = 2;

  localparam logic [2:0] ERR_OK     = 3'd0;
  localparam logic [2:0] ERR_UNDER  = 3'd1;
  localparam logic [2:0] ERR_OVER   = 3'd2;
  localparam logic [2:0] ERR_JUMP   = 3'd3;
  localparam logic [2:0] ERR_SPRITE = 3'd4;
  localparam logic [2:0] ERR_DIGIT  = 3'd5;
  localparam logic [2:0] ERR_BCD    = 3'd6;
  localparam logic [2:0] ERR_BLOCK  = 3'd7;

  localparam logic [1:0] MODE_EXEC = 2'd0;
  localparam logic [1:0] MODE_LOAD = 2'd1;
  localparam logic [1:0] MODE_ROW  = 2'd2;

  localparam logic [1:0] CFG_SHIFT_X = 2'd0;
  localparam logic [1:0] CFG_KEEP_I  = 2'd1;
  localparam logic [1:0] CFG_WRAP    = 2'd2;

  typedef enum logic [4:0] {
    CL_NOP, CL_CLS, CL_RET, CL_JP, CL_CALL, CL_SKIP, CL_ALU, CL_LDI,
    CL_JPV0, CL_RND, CL_DRW, CL_FMISC, CL_WAITKEY, CL_BCD, CL_STORE,
    CL_LOAD, CL_MEMLD, CL_ROW, CL_HOLD
  } cls_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [15:0]       opcode;
    logic [15:0]       keys;
    logic [7:0]        rand_byte;
    logic [11:0]       load_addr;
    logic [7:0]        load_data;
    logic [4:0]        row_select;
  } raw_t;

  typedef struct packed {
    cls_t              cls;
    raw_t              raw;
  } item_t;

  typedef struct packed {
    logic              shift_uses_x;
    logic              keep_index;
    logic              sprite_wrap;
  } cfg_t;

  typedef struct packed {
    logic [11:0]       pc;
    logic [15:0]       index_value;
    logic [4:0]        stack_depth;
    logic [7:0]        flag_reg;
    logic [2:0]        error_code;
    logic [7:0]        delay_value;
    logic [7:0]        sound_value;
    logic              waiting_key;
    logic [63:0]       display_row_bits;
  } res_t;

  // decimal digit sel (0 hundreds, 1 tens, 2 ones) of a byte
  function automatic logic [7:0] bcd_digit(input logic [7:0] v, input logic [1:0] sel);
    logic [1:0] h;
    logic [7:0] r;
    logic [3:0] t;
    logic [7:0] o;
    h = (v >= 8'd200) ? 2'd2 : (v >= 8'd100) ? 2'd1 : 2'd0;
    r = v - 8'(h * 8'd100);
    t = '0;
    for (int k = 1; k <= 9; k++) begin
      if (r >= 8'(k * 10)) t = 4'(k);
    end
    o = r - 8'(t * 8'd10);
    case (sel)
      2'd0:    bcd_digit = {6'd0, h};
      2'd1:    bcd_digit = {4'd0, t};
      default: bcd_digit = o;
    endcase
  endfunction

endpackage

`default_nettype wire

// File: src/chip8_instruction_execute.sv
// ----------------------------------------------------------------------------
// chip8_instruction_execute
// CHIP-8 execute unit: front queue of two items, sequential executor.
// ----------------------------------------------------------------------------
// Steps: single-step items finish in the execute state; sprite draw reads
//   and writes each row, BCD writes 3 digits, store/load move V0..Vx in turn.
// Throughput: one item at a time in the executor; the output register
//   holds one result, and the next item starts once it is taken.
// Reset: synchronous active low; registers, display and queues cleared,
//   pc at 0x200; memory and return stack keep their contents.
`default_nettype none

module chip8_instruction_execute
  import c8ie_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [1:0]  in_mode,
  input  wire logic [15:0] in_opcode,
  input  wire logic [15:0] in_keys,
  input  wire logic [7:0]  in_rand_byte,
  input  wire logic [11:0] in_load_addr,
  input  wire logic [7:0]  in_load_data,
  input  wire logic [4:0]  in_row_select,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [11:0]      out_pc,
  output logic [15:0]      out_index_value,
  output logic [4:0]       out_stack_depth,
  output logic [7:0]       out_flag_reg,
  output logic [2:0]       out_error_code,
  output logic [7:0]       out_delay_value,
  output logic [7:0]       out_sound_value,
  output logic             out_waiting_key,
  output logic [63:0]      out_display_row_bits,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic        cfg_data
);

  cfg_t  cfg_r;
  raw_t  raw;
  item_t q_item;
  logic  q_valid;
  logic  q_pop;
  logic  out_valid;
  res_t  res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SHIFT_X: cfg_r.shift_uses_x <= cfg_data;
        CFG_KEEP_I:  cfg_r.keep_index   <= cfg_data;
        CFG_WRAP:    cfg_r.sprite_wrap  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign raw = '{mode: in_mode, opcode: in_opcode, keys: in_keys, rand_byte: in_rand_byte,
                 load_addr: in_load_addr, load_data: in_load_data, row_select: in_row_select};

  c8ie_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_push),
    .full    (in_full),
    .raw     (raw),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_item  (q_item)
  );

  c8ie_exec u_exec (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .out_valid (out_valid),
    .out_take  (out_pop),
    .out_res   (res)
  );

  assign out_empty            = !out_valid;
  assign out_pc               = res.pc;
  assign out_index_value      = res.index_value;
  assign out_stack_depth      = res.stack_depth;
  assign out_flag_reg         = res.flag_reg;
  assign out_error_code       = res.error_code;
  assign out_delay_value      = res.delay_value;
  assign out_sound_value      = res.sound_value;
  assign out_waiting_key      = res.waiting_key;
  assign out_display_row_bits = res.display_row_bits;

endmodule

`default_nettype wire

// File: src/c8ie_front.sv
// ----------------------------------------------------------------------------
// c8ie_front
// Accepts items, classifies the opcode and queues them for the executor.
// ----------------------------------------------------------------------------
`default_nettype none

module c8ie_front
  import c8ie_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  output logic       full,
  input  wire raw_t  raw,
  output logic       q_valid,
  input  wire logic  q_pop,
  output item_t      q_item
);

  item_t      ent_r [Q_DEPTH];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  cls_t       cls;
  logic       do_push;

  always_comb begin
    logic [15:0] op;
    op  = raw.opcode;
    cls = CL_NOP;
    case (raw.mode)
      MODE_EXEC: begin
        case (op[15:12])
          4'h0: cls = (op == 16'h00E0) ? CL_CLS : (op == 16'h00EE) ? CL_RET : CL_NOP;
          4'h1: cls = CL_JP;
          4'h2: cls = CL_CALL;
          4'h3, 4'h4: cls = CL_SKIP;
          4'h5, 4'h9: cls = (op[3:0] == 4'h0) ? CL_SKIP : CL_NOP;
          4'h6, 4'h7: cls = CL_ALU;
          4'h8: begin
            if (op[3:0] inside {4'h0, 4'h1, 4'h2, 4'h3, 4'h4, 4'h5, 4'h6, 4'h7, 4'hE})
              cls = CL_ALU;
          end
          4'hA: cls = CL_LDI;
          4'hB: cls = CL_JPV0;
          4'hC: cls = CL_RND;
          4'hD: cls = CL_DRW;
          4'hE: cls = (op[7:0] == 8'h9E || op[7:0] == 8'hA1) ? CL_SKIP : CL_NOP;
          default: begin
            case (op[7:0])
              8'h07, 8'h15, 8'h18, 8'h1E, 8'h29: cls = CL_FMISC;
              8'h0A:   cls = CL_WAITKEY;
              8'h33:   cls = CL_BCD;
              8'h55:   cls = CL_STORE;
              8'h65:   cls = CL_LOAD;
              default: cls = CL_NOP;
            endcase
          end
        endcase
      end
      MODE_LOAD: cls = CL_MEMLD;
      MODE_ROW:  cls = CL_ROW;
      default:   cls = CL_HOLD;
    endcase
  end

  assign full    = (cnt_r == 2'(Q_DEPTH));
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = ent_r[rd_ptr_r];
  assign do_push = push && !full;

  always_ff @(posedge clk) begin
    if (do_push) ent_r[wr_ptr_r] <= '{cls: cls, raw: raw};
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (q_pop)   rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + 2'(do_push) - 2'(q_pop);
    end
  end

endmodule

`default_nettype wire

// File: src/c8ie_exec.sv
// ----------------------------------------------------------------------------
// c8ie_exec
// Carries out queued items: register file, stack, memory, display, result.
// ----------------------------------------------------------------------------
`default_nettype none

module c8ie_exec
  import c8ie_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire cfg_t  cfg,
  input  wire logic  q_valid,
  output logic       q_pop,
  input  wire item_t q_item,
  output logic       out_valid,
  input  wire logic  out_take,
  output res_t       out_res
);

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_SPR_RD, S_SPR_WR, S_BCD, S_BLK_ST, S_BLK_RD, S_BLK_WR
  } state_t;

  state_t             state_r;
  item_t              cur_r;
  logic [7:0]         v_r     [16];
  logic [11:0]        stk_r   [STACK_DEPTH];
  logic [SCREEN_W-1:0] frame_r [SCREEN_H];
  logic [15:0]        index_r;
  logic [11:0]        pc_r;
  logic [4:0]         sp_r;
  logic [7:0]         delay_r;
  logic [7:0]         sound_r;
  logic [3:0]         cnt_r;
  logic               hit_r;
  logic [2:0]         err_r;
  logic               wait_r;
  logic [63:0]        row_r;
  logic               fin_r;
  logic               out_valid_r;
  res_t               out_r;

  logic [7:0]         mem [MEM_BYTES];
  logic [7:0]         rdata_r;
  logic               mem_we;
  logic [MEM_AW-1:0]  mem_addr;
  logic [7:0]         mem_wdata;

  logic [3:0]  x, y, n;
  logic [7:0]  kk, vx, vy;
  logic [11:0] nnn;
  logic [11:0] pc2, pc4;
  logic        skip;
  logic [7:0]  alu_res;
  logic        alu_flag, alu_setf;
  logic [3:0]  low_key;
  logic [8:0]  ny;
  logic        ny_ok;
  logic [SCREEN_W-1:0] mask;
  logic [15:0] idx_cnt;

  assign x   = cur_r.raw.opcode[11:8];
  assign y   = cur_r.raw.opcode[7:4];
  assign n   = cur_r.raw.opcode[3:0];
  assign kk  = cur_r.raw.opcode[7:0];
  assign nnn = cur_r.raw.opcode[11:0];
  assign vx  = v_r[x];
  assign vy  = v_r[y];
  assign pc2 = pc_r + 12'd2;
  assign pc4 = pc_r + 12'd4;
  assign idx_cnt = index_r + 16'(cnt_r);

  always_comb begin
    logic down;
    down = cur_r.raw.keys[vx[3:0]];
    case (cur_r.raw.opcode[15:12])
      4'h3:    skip = (vx == kk);
      4'h4:    skip = (vx != kk);
      4'h5:    skip = (vx == vy);
      4'h9:    skip = (vx != vy);
      default: skip = (kk == 8'h9E) ? down : !down;
    endcase
  end

  always_comb begin
    logic [7:0] s;
    logic [8:0] sum;
    s        = cfg.shift_uses_x ? vx : vy;
    sum      = {1'b0, vx} + {1'b0, vy};
    alu_res  = vx;
    alu_flag = 1'b0;
    alu_setf = 1'b0;
    if (cur_r.raw.opcode[15:12] == 4'h6) begin
      alu_res = kk;
    end else if (cur_r.raw.opcode[15:12] == 4'h7) begin
      alu_res = vx + kk;
    end else begin
      case (n)
        4'h0: alu_res = vy;
        4'h1: alu_res = vx | vy;
        4'h2: alu_res = vx & vy;
        4'h3: alu_res = vx ^ vy;
        4'h4: begin alu_res = sum[7:0]; alu_flag = sum[8]; alu_setf = 1'b1; end
        4'h5: begin alu_res = vx - vy; alu_flag = (vx >= vy); alu_setf = 1'b1; end
        4'h7: begin alu_res = vy - vx; alu_flag = (vy >= vx); alu_setf = 1'b1; end
        4'h6: begin alu_res = s >> 1; alu_flag = s[0]; alu_setf = 1'b1; end
        default: begin alu_res = s << 1; alu_flag = s[7]; alu_setf = 1'b1; end
      endcase
    end
  end

  always_comb begin
    low_key = 4'd0;
    for (int k = 15; k >= 0; k--) begin
      if (cur_r.raw.keys[k]) low_key = 4'(k);
    end
  end

  always_comb begin
    logic [8:0] col;
    ny    = {1'b0, vy} + 9'(cnt_r);
    ny_ok = cfg.sprite_wrap || (ny < 9'(SCREEN_H));
    mask  = '0;
    for (int c = 0; c < 8; c++) begin
      col = {1'b0, vx} + 9'(c);
      if (rdata_r[7-c] && (cfg.sprite_wrap || col < 9'(SCREEN_W)))
        mask[COL_AW'(SCREEN_W-1) - col[COL_AW-1:0]] = 1'b1;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = idx_cnt[MEM_AW-1:0];
    mem_wdata = v_r[cnt_r];
    case (state_r)
      S_EXEC: begin
        if (cur_r.cls == CL_MEMLD) begin
          mem_we    = 1'b1;
          mem_addr  = cur_r.raw.load_addr[MEM_AW-1:0];
          mem_wdata = cur_r.raw.load_data;
        end
      end
      S_BCD: begin
        mem_we    = 1'b1;
        mem_wdata = bcd_digit(vx, cnt_r[1:0]);
      end
      S_BLK_ST: mem_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    rdata_r <= mem[mem_addr];
  end

  assign q_pop     = (state_r == S_IDLE) && q_valid && !out_valid_r && !fin_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      fin_r       <= 1'b0;
      index_r     <= '0;
      pc_r        <= 12'h200;
      sp_r        <= '0;
      delay_r     <= '0;
      sound_r     <= '0;
      for (int i = 0; i < 16; i++) v_r[i] <= '0;
      for (int i = 0; i < SCREEN_H; i++) frame_r[i] <= '0;
    end else begin
      fin_r <= 1'b0;
      if (out_valid_r && out_take) out_valid_r <= 1'b0;
      if (fin_r) begin
        out_valid_r <= 1'b1;
        out_r <= '{pc: pc_r, index_value: index_r, stack_depth: sp_r, flag_reg: v_r[15],
                   error_code: err_r, delay_value: delay_r, sound_value: sound_r,
                   waiting_key: wait_r, display_row_bits: row_r};
      end
      case (state_r)
        S_IDLE: begin
          if (q_pop) begin
            cur_r   <= q_item;
            err_r   <= ERR_OK;
            wait_r  <= 1'b0;
            row_r   <= '0;
            cnt_r   <= '0;
            hit_r   <= 1'b0;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_r <= S_IDLE;
          fin_r   <= 1'b1;
          case (cur_r.cls)
            CL_NOP: pc_r <= pc2;
            CL_CLS: begin
              for (int i = 0; i < SCREEN_H; i++) frame_r[i] <= '0;
              pc_r <= pc2;
            end
            CL_RET: begin
              if (sp_r == 5'd0) err_r <= ERR_UNDER;
              else begin
                sp_r <= sp_r - 5'd1;
                pc_r <= stk_r[SP_AW'(sp_r - 5'd1)] + 12'd2;
              end
            end
            CL_JP: pc_r <= nnn;
            CL_CALL: begin
              if (sp_r >= 5'(STACK_DEPTH)) err_r <= ERR_OVER;
              else begin
                stk_r[sp_r[SP_AW-1:0]] <= pc_r;
                sp_r <= sp_r + 5'd1;
                pc_r <= nnn;
              end
            end
            CL_SKIP: pc_r <= skip ? pc4 : pc2;
            CL_ALU: begin
              v_r[x] <= alu_res;
              if (alu_setf) v_r[15] <= {7'd0, alu_flag};
              pc_r <= pc2;
            end
            CL_LDI: begin index_r <= {4'd0, nnn}; pc_r <= pc2; end
            CL_JPV0: begin
              if (({1'b0, nnn} + {5'd0, v_r[0]}) >= 13'(MEM_BYTES)) err_r <= ERR_JUMP;
              else pc_r <= nnn + {4'd0, v_r[0]};
            end
            CL_RND: begin
              v_r[x] <= ((cur_r.raw.rand_byte == 8'hFF) ? 8'd0 : cur_r.raw.rand_byte) & kk;
              pc_r <= pc2;
            end
            CL_DRW: begin
              if (({1'b0, index_r} + 17'(n)) > 17'(MEM_BYTES)) err_r <= ERR_SPRITE;
              else if (n == 4'd0) begin
                v_r[15] <= 8'd0;
                pc_r    <= pc2;
              end else begin
                fin_r   <= 1'b0;
                state_r <= S_SPR_RD;
              end
            end
            CL_FMISC: begin
              pc_r <= pc2;
              case (kk)
                8'h07: v_r[x] <= delay_r;
                8'h15: delay_r <= vx;
                8'h18: sound_r <= vx;
                8'h1E: index_r <= index_r + {8'd0, vx};
                default: begin
                  if (vx > 8'd15) begin
                    err_r <= ERR_DIGIT;
                    pc_r  <= pc_r;
                  end else index_r <= 16'(vx * 8'd5);
                end
              endcase
            end
            CL_WAITKEY: begin
              if (cur_r.raw.keys == 16'd0) wait_r <= 1'b1;
              else begin
                v_r[x] <= {4'd0, low_key};
                pc_r   <= pc2;
              end
            end
            CL_BCD: begin
              if (({1'b0, index_r} + 17'd2) >= 17'(MEM_BYTES)) err_r <= ERR_BCD;
              else begin
                fin_r   <= 1'b0;
                state_r <= S_BCD;
              end
            end
            CL_STORE, CL_LOAD: begin
              if (({1'b0, index_r} + 17'(x)) >= 17'(MEM_BYTES)) err_r <= ERR_BLOCK;
              else begin
                fin_r   <= 1'b0;
                state_r <= (cur_r.cls == CL_STORE) ? S_BLK_ST : S_BLK_RD;
              end
            end
            CL_ROW: row_r <= frame_r[cur_r.raw.row_select[ROW_AW-1:0]];
            default: ;
          endcase
        end
        S_SPR_RD: state_r <= S_SPR_WR;
        S_SPR_WR: begin
          if (ny_ok) frame_r[ny[ROW_AW-1:0]] <= frame_r[ny[ROW_AW-1:0]] ^ mask;
          if (cnt_r == n - 4'd1) begin
            v_r[15] <= {7'd0, hit_r || (ny_ok && |(frame_r[ny[ROW_AW-1:0]] & mask))};
            pc_r    <= pc2;
            fin_r   <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            hit_r   <= hit_r || (ny_ok && |(frame_r[ny[ROW_AW-1:0]] & mask));
            cnt_r   <= cnt_r + 4'd1;
            state_r <= S_SPR_RD;
          end
        end
        S_BCD: begin
          if (cnt_r == 4'd2) begin
            pc_r    <= pc2;
            fin_r   <= 1'b1;
            state_r <= S_IDLE;
          end else cnt_r <= cnt_r + 4'd1;
        end
        S_BLK_RD: state_r <= S_BLK_WR;
        S_BLK_ST, S_BLK_WR: begin
          if (state_r == S_BLK_WR) v_r[cnt_r] <= rdata_r;
          if (cnt_r == x) begin
            if (!cfg.keep_index) index_r <= index_r + {12'd0, x} + 16'd1;
            pc_r    <= pc2;
            fin_r   <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            cnt_r   <= cnt_r + 4'd1;
            state_r <= (state_r == S_BLK_WR) ? S_BLK_RD : S_BLK_ST;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: src/c8ie_checker.sv
// ----------------------------------------------------------------------------
// c8ie_checker
// Port-level checks of the CHIP-8 execute block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module c8ie_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_full,
  input wire logic        out_empty,
  input wire logic        out_pop,
  input wire logic [11:0] out_pc,
  input wire logic [4:0]  out_stack_depth,
  input wire logic [2:0]  out_error_code,
  input wire logic        out_waiting_key
);

  a_empty_after_reset: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result visible right after reset");

  a_room_after_reset: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("queue full right after reset");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_pc))
    else $error("waiting result changed");

  a_err_no_wait: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_error_code != 3'd0 |-> !out_waiting_key)
    else $error("error and key wait together");

  a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_stack_depth <= 5'd16)
    else $error("stack depth out of range");

endmodule

bind chip8_instruction_execute c8ie_checker u_c8ie_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_full         (in_full),
  .out_empty       (out_empty),
  .out_pop         (out_pop),
  .out_pc          (out_pc),
  .out_stack_depth (out_stack_depth),
  .out_error_code  (out_error_code),
  .out_waiting_key (out_waiting_key)
);

`default_nettype wire

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the CHIP-8 execute unit: a queue-fed driver pushes
// directed then random items, a running machine model predicts each result,
// and a monitor pops and compares results field by field under random idling.
// ----------------------------------------------------------------------------
module tb;
  import c8ie_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WDOG_LIMIT = 5000;
  localparam int SETTLE     = 60;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic [1:0] in_mode = '0;
  logic [15:0] in_opcode = '0;
  logic [15:0] in_keys = '0;
  logic [7:0] in_rand_byte = '0;
  logic [11:0] in_load_addr = '0;
  logic [7:0] in_load_data = '0;
  logic [4:0] in_row_select = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic [11:0] out_pc;
  logic [15:0] out_index_value;
  logic [4:0] out_stack_depth;
  logic [7:0] out_flag_reg;
  logic [2:0] out_error_code;
  logic [7:0] out_delay_value;
  logic [7:0] out_sound_value;
  logic out_waiting_key;
  logic [63:0] out_display_row_bits;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic cfg_data = 1'b0;

  chip8_instruction_execute dut (.*);

  always #1 clk = ~clk;

  raw_t pending[$];
  res_t awaited[$];
  int fails = 0;
  int send_idle = 0;
  int recv_stall = 0;
  int quiet = 0;

  // machine copy
  logic [7:0] v[16];
  logic [15:0] idx;
  logic [11:0] pc;
  logic [4:0] sp;
  logic [11:0] rstack[16];
  logic [7:0] dt, st;
  logic [7:0] mem[MEM_BYTES];
  bit written[MEM_BYTES];
  logic [63:0] fb[SCREEN_H];
  bit c_shift_x, c_keep_i, c_wrap;

  task automatic run_op(input raw_t it, output logic [2:0] er, output logic wt);
    logic [15:0] op;
    int x, y, n, kk, nnn, vx, vy, s, res, flag, i, ny, nx, hit;
    logic [7:0] bits;
    bit adv, setf;
    op = it.opcode;
    x = op[11:8]; y = op[7:4]; n = op[3:0]; kk = op[7:0]; nnn = op[11:0];
    vx = v[x]; vy = v[y];
    er = ERR_OK; wt = 1'b0; adv = 1; setf = 0; res = 0; flag = 0;
    case (op[15:12])
      4'h0: begin
        if (op == 16'h00E0) begin
          for (i = 0; i < SCREEN_H; i++) fb[i] = '0;
        end else if (op == 16'h00EE) begin
          adv = 0;
          if (sp == 0) er = ERR_UNDER;
          else begin
            sp = sp - 1;
            pc = rstack[sp] + 12'd2;
          end
        end
      end
      4'h1: begin adv = 0; pc = nnn[11:0]; end
      4'h2: begin
        adv = 0;
        if (sp >= STACK_DEPTH) er = ERR_OVER;
        else begin
          rstack[sp] = pc; sp = sp + 1; pc = nnn[11:0];
        end
      end
      4'h3: begin adv = 0; pc = pc + ((vx == kk) ? 12'd4 : 12'd2); end
      4'h4: begin adv = 0; pc = pc + ((vx != kk) ? 12'd4 : 12'd2); end
      4'h5: if (n == 0) begin adv = 0; pc = pc + ((vx == vy) ? 12'd4 : 12'd2); end
      4'h6: v[x] = kk[7:0];
      4'h7: v[x] = 8'(vx + kk);
      4'h8: begin
        case (n)
          0: v[x] = vy[7:0];
          1: v[x] = 8'(vx | vy);
          2: v[x] = 8'(vx & vy);
          3: v[x] = 8'(vx ^ vy);
          4: begin res = vx + vy; flag = (res > 255); setf = 1; end
          5: begin res = vx - vy; flag = (vx >= vy); setf = 1; end
          7: begin res = vy - vx; flag = (vy >= vx); setf = 1; end
          6: begin s = c_shift_x ? vx : vy; res = s >> 1; flag = s & 1; setf = 1; end
          14: begin s = c_shift_x ? vx : vy; res = s << 1; flag = (s >> 7) & 1; setf = 1; end
          default: ;
        endcase
        if (setf) begin v[x] = 8'(res); v[15] = 8'(flag); end
      end
      4'h9: if (n == 0) begin adv = 0; pc = pc + ((vx != vy) ? 12'd4 : 12'd2); end
      4'hA: idx = 16'(nnn);
      4'hB: begin
        adv = 0;
        res = nnn + v[0];
        if (res >= 4096) er = ERR_JUMP;
        else pc = res[11:0];
      end
      4'hC: v[x] = 8'((it.rand_byte % 255) & kk);
      4'hD: begin
        if (idx + n > MEM_BYTES) begin
          adv = 0; er = ERR_SPRITE;
        end else begin
          hit = 0;
          for (int r = 0; r < n; r++) begin
            bits = mem[(idx + r) % MEM_BYTES];
            ny = vy + r;
            if (c_wrap) ny = ny % SCREEN_H;
            if (ny < SCREEN_H) begin
              for (int c = 0; c < 8; c++) begin
                nx = vx + c;
                if (c_wrap) nx = nx % SCREEN_W;
                if (nx < SCREEN_W && bits[7-c]) begin
                  if (fb[ny][63-nx]) hit = 1;
                  fb[ny][63-nx] = ~fb[ny][63-nx];
                end
              end
            end
          end
          v[15] = 8'(hit);
        end
      end
      4'hE: begin
        if (kk == 8'h9E) begin
          adv = 0; pc = pc + (it.keys[vx[3:0]] ? 12'd4 : 12'd2);
        end else if (kk == 8'hA1) begin
          adv = 0; pc = pc + (it.keys[vx[3:0]] ? 12'd2 : 12'd4);
        end
      end
      default: begin
        case (kk)
          8'h07: v[x] = dt;
          8'h0A: begin
            if (it.keys == 0) begin
              adv = 0; wt = 1'b1;
            end else begin
              for (i = 15; i >= 0; i--) if (it.keys[i]) v[x] = 8'(i);
            end
          end
          8'h15: dt = vx[7:0];
          8'h18: st = vx[7:0];
          8'h1E: idx = 16'(idx + vx);
          8'h29: begin
            if (vx > 15) begin adv = 0; er = ERR_DIGIT; end
            else idx = 16'(vx * 5);
          end
          8'h33: begin
            if (idx + 2 >= MEM_BYTES) begin adv = 0; er = ERR_BCD; end
            else begin
              mem[idx] = 8'(vx / 100); mem[idx+1] = 8'((vx / 10) % 10);
              mem[idx+2] = 8'(vx % 10);
              written[idx] = 1; written[idx+1] = 1; written[idx+2] = 1;
            end
          end
          8'h55, 8'h65: begin
            if (idx + x >= MEM_BYTES) begin adv = 0; er = ERR_BLOCK; end
            else begin
              for (i = 0; i <= x; i++) begin
                if (kk == 8'h55) begin
                  mem[idx+i] = v[i]; written[idx+i] = 1;
                end else v[i] = mem[idx+i];
              end
              if (!c_keep_i) idx = 16'(idx + x + 1);
            end
          end
          default: ;
        endcase
      end
    endcase
    if (adv) pc = pc + 12'd2;
  endtask

  task automatic machine_step(input raw_t it);
    res_t r;
    logic [2:0] er;
    logic wt;
    er = ERR_OK; wt = 1'b0;
    r.display_row_bits = '0;
    case (it.mode)
      MODE_EXEC: run_op(it, er, wt);
      MODE_LOAD: begin mem[it.load_addr] = it.load_data; written[it.load_addr] = 1; end
      MODE_ROW: r.display_row_bits = fb[it.row_select];
      default: ;
    endcase
    r.pc = pc; r.index_value = idx; r.stack_depth = sp; r.flag_reg = v[15];
    r.error_code = er; r.delay_value = dt; r.sound_value = st; r.waiting_key = wt;
    awaited.push_back(r);
  endtask

  task automatic add_item(input raw_t it);
    machine_step(it);
    pending.push_back(it);
  endtask

  function automatic raw_t mk_item(input logic [1:0] m, input logic [15:0] op);
    raw_t it;
    it.mode = m; it.opcode = op;
    it.keys = ($urandom_range(4) == 0) ? 16'h0 : 16'($urandom);
    it.rand_byte = 8'($urandom_range(254));
    it.load_addr = 12'($urandom); it.load_data = 8'($urandom);
    it.row_select = 5'($urandom);
    return it;
  endfunction

  // preload any unwritten byte a sprite draw or register load would read
  task automatic add_exec(input logic [15:0] op, input logic [15:0] keys);
    raw_t it;
    int lo, cnt;
    cnt = 0; lo = idx;
    if (op[15:12] == 4'hD && op[3:0] != 0 && idx + op[3:0] <= MEM_BYTES) cnt = op[3:0];
    if (op[15:12] == 4'hF && op[7:0] == 8'h65 && idx + op[11:8] < MEM_BYTES) cnt = op[11:8] + 1;
    for (int a = lo; a < lo + cnt; a++) begin
      if (!written[a]) begin
        it = mk_item(MODE_LOAD, 16'($urandom));
        it.load_addr = 12'(a);
        add_item(it);
      end
    end
    it = mk_item(MODE_EXEC, op);
    it.keys = keys;
    add_item(it);
  endtask

  function automatic logic [15:0] pick_op();
    logic [15:0] op;
    logic [7:0] fk[10];
    fk = '{8'h07, 8'h0A, 8'h15, 8'h18, 8'h1E, 8'h29, 8'h33, 8'h55, 8'h65, 8'h00};
    op = 16'($urandom);
    case (op[15:12])
      4'h0: case ($urandom_range(5))
        0: op = 16'h00E0;
        1, 2, 3: op = 16'h00EE;
        default: ;
      endcase
      4'h5, 4'h9: if ($urandom_range(3) != 0) op[3:0] = 4'h0;
      4'hA: if ($urandom_range(3) != 0) op[11:0] = 12'($urandom_range(400));
      4'hE: if ($urandom_range(7) != 0) op[7:0] = $urandom_range(1) ? 8'h9E : 8'hA1;
      4'hF: begin
        fk[9] = 8'($urandom);
        op[7:0] = fk[$urandom_range(9)];
      end
      default: ;
    endcase
    return op;
  endfunction

  task automatic cfg_write(input logic [1:0] ix, input logic d);
    @(posedge clk);
    cfg_valid <= 1'b1; cfg_index <= ix; cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (ix)
      CFG_SHIFT_X: c_shift_x = d;
      CFG_KEEP_I:  c_keep_i = d;
      default:     c_wrap = d;
    endcase
  endtask

  task automatic drain();
    while (pending.size() != 0 || in_push || awaited.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cmp(input string nm, input logic [63:0] e, input logic [63:0] a);
    if (e !== a) begin
      fails++;
      $display("%0t: %s expected %h actual %h", $realtime, nm, e, a);
    end
  endtask

  // driver
  always @(posedge clk) begin
    raw_t it;
    if (!rst_n) begin
      in_push <= 1'b0;
    end else if (!in_push || !in_full) begin
      if (pending.size() != 0 && $urandom_range(99) >= send_idle) begin
        it = pending.pop_front();
        in_push <= 1'b1;
        in_mode <= it.mode; in_opcode <= it.opcode; in_keys <= it.keys;
        in_rand_byte <= it.rand_byte; in_load_addr <= it.load_addr;
        in_load_data <= it.load_data; in_row_select <= it.row_select;
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    res_t e;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (awaited.size() == 0) begin
          fails++;
          $display("%0t: unexpected result, pc %h", $realtime, out_pc);
        end else begin
          e = awaited.pop_front();
          cmp("pc", e.pc, out_pc);
          cmp("index_value", e.index_value, out_index_value);
          cmp("stack_depth", e.stack_depth, out_stack_depth);
          cmp("flag_reg", e.flag_reg, out_flag_reg);
          cmp("error_code", e.error_code, out_error_code);
          cmp("delay_value", e.delay_value, out_delay_value);
          cmp("sound_value", e.sound_value, out_sound_value);
          cmp("waiting_key", e.waiting_key, out_waiting_key);
          cmp("display_row_bits", e.display_row_bits, out_display_row_bits);
        end
      end
      out_pop <= ($urandom_range(99) >= recv_stall);
      if ((out_pop && !out_empty) || (in_push && !in_full) || (cfg_valid && cfg_ready))
        quiet <= 0;
      else
        quiet <= quiet + 1;
      if (quiet >= WDOG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    raw_t it;
    bit [2:0] cfgs[5];
    int idle_s[4], idle_r[4];
    cfgs = '{3'b000, 3'b111, 3'b101, 3'b010, 3'b000};
    idle_s = '{0, 55, 0, 12};
    idle_r = '{0, 0, 55, 12};
    for (int i = 0; i < 16; i++) begin v[i] = '0; rstack[i] = '0; end
    for (int i = 0; i < SCREEN_H; i++) fb[i] = '0;
    for (int i = 0; i < MEM_BYTES; i++) begin mem[i] = '0; written[i] = 0; end
    idx = '0; pc = 12'h200; sp = '0; dt = '0; st = '0;
    c_shift_x = 0; c_keep_i = 0; c_wrap = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed
    add_exec(16'h60FF, 16'hFFFF);
    add_exec(16'h6101, 16'h0);
    add_exec(16'h8014, 16'h0);
    add_exec(16'h8F15, 16'h0);
    add_exec(16'h8017, 16'h0);
    add_exec(16'h801E, 16'h0);
    add_exec(16'h8016, 16'h0);
    add_exec(16'hC2FF, 16'h0);
    add_exec(16'h00EE, 16'h0);
    add_exec(16'h2FFE, 16'h0);
    add_exec(16'h00EE, 16'h0);
    add_exec(16'h60FF, 16'h0);
    add_exec(16'hBFFF, 16'h0);
    add_exec(16'hF029, 16'h0);
    add_exec(16'hAFFE, 16'h0);
    add_exec(16'hF033, 16'h0);
    add_exec(16'hFF55, 16'h0);
    add_exec(16'hD00F, 16'h0);
    add_exec(16'hA000, 16'h0);
    add_exec(16'hD015, 16'h0);
    add_exec(16'hD010, 16'h0);
    add_exec(16'hF30A, 16'h0);
    add_exec(16'hF30A, 16'h8000);
    add_exec(16'hE39E, 16'h8000);
    add_exec(16'hE3A1, 16'h8000);
    add_exec(16'h5011, 16'h0);
    it = mk_item(MODE_ROW, 16'h0); it.row_select = 5'd1; add_item(it);
    it = mk_item(2'd3, 16'h0); add_item(it);
    add_exec(16'h00E0, 16'h0);
    add_exec(16'h1FFF, 16'h0);

    for (int ph = 0; ph < 5; ph++) begin
      drain();
      send_idle = idle_s[ph % 4];
      recv_stall = idle_r[ph % 4];
      cfg_write(CFG_SHIFT_X, cfgs[ph][2]);
      cfg_write(CFG_KEEP_I, cfgs[ph][1]);
      cfg_write(CFG_WRAP, (ph == 4) ? 1'($urandom) : cfgs[ph][0]);
      for (int k = 0; k < 100; k++) begin
        case ($urandom_range(99)) inside
          [0:74]:  add_exec(pick_op(), ($urandom_range(4) == 0) ? 16'h0 : 16'($urandom));
          [75:84]: add_item(mk_item(MODE_LOAD, 16'($urandom)));
          [85:96]: add_item(mk_item(MODE_ROW, 16'($urandom)));
          default: add_item(mk_item(2'd3, 16'($urandom)));
        endcase
      end
    end
    drain();
    if (fails == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule

// File: chip8_instruction_execute.f
src/c8ie_pkg.sv
src/c8ie_front.sv
src/c8ie_exec.sv
src/chip8_instruction_execute.sv
src/c8ie_checker.sv
tb/tb.sv
